// ----- rtl/i2cram_pkg.sv -----
// shared types and constants for the i2c register access master
// no dependencies; imported by every rtl file of the block
package i2cram_pkg;

    // bus sequencer segments
    typedef enum logic [3:0] {
        SEG_IDLE    = 4'd0,
        SEG_START   = 4'd1,
        SEG_DEVW    = 4'd2,
        SEG_REG     = 4'd3,
        SEG_DATA    = 4'd4,
        SEG_RESTART = 4'd5,
        SEG_DEVR    = 4'd6,
        SEG_RECV    = 4'd7,
        SEG_STOP    = 4'd8
    } seg_t;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // read/write bit appended to the device address
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd400;
    localparam logic [3:0]  BYTE_BITS         = 4'd8;
    localparam logic [3:0]  LAST_BIT          = 4'd7;
    localparam logic [1:0]  COND_LAST_SUB     = 2'd2;

    // one input beat
    typedef struct packed {
        logic       start_request;
        logic       command;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_in;
    } i2cram_in_t;

    // one result beat
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } i2cram_out_t;

endpackage

// ----- rtl/i2c_register_access_master.sv -----
// Single-byte I2C register read/write master. Every request beat is one bus tick:
// the sequencer advances once per accepted beat and returns exactly one response
// beat with the SCL/SDA drive levels, busy, done and the last read byte. A beat is
// accepted every cycle while req_stall is low, and its response is registered; a two-entry
// output buffer (result register plus skid register) lets one more beat in while
// the response side stalls, after which req_stall rises. Bus timing counts beats,
// phase_ticks (cfg_wr_data) of them per waveform step, zero meaning one.
// Depends on i2cram_pkg and i2cram_seq.
module i2c_register_access_master
    import i2cram_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  i2cram_in_t  req_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output i2cram_out_t rsp_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic        accept;
    logic        take;
    i2cram_out_t result;

    logic        out_valid_reg, out_valid_next;
    i2cram_out_t out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    i2cram_out_t skid_data_reg, skid_data_next;

    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !req_stall;
    assign take      = out_valid_reg && !rsp_stall;

    i2cram_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .req         (req_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp         (result)
    );

    // output register and skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (take && skid_valid_reg)
        begin
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            out_valid_next = accept;
            if (accept)
            begin
                out_data_next = result;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // beat payloads
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

// ----- rtl/i2cram_seq.sv -----
// bus sequencer: state registers and one-tick step logic of the i2c master
// depends on i2cram_pkg
module i2cram_seq
    import i2cram_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  i2cram_in_t  req,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output i2cram_out_t rsp
);

    seg_t        seg_reg, seg_next;
    logic [1:0]  sub_reg, sub_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  tx_reg, tx_next;
    logic [7:0]  rx_reg, rx_next;
    logic [15:0] tick_reg, tick_next;
    logic [6:0]  dev_reg, dev_next;
    logic [7:0]  regaddr_reg, regaddr_next;
    logic [7:0]  wdata_reg, wdata_next;
    logic        cmd_reg, cmd_next;
    logic [7:0]  rdata_reg, rdata_next;
    logic [15:0] phase_ticks_reg;

    logic [15:0] limit;
    logic        step_end;
    logic        enter;
    seg_t        enter_seg;
    logic        done;
    logic [7:0]  rx_shifted;

    // phase length register, zero acts as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            phase_ticks_reg <= cfg_wr_data;
        end
    end

    assign limit      = (phase_ticks_reg == 16'd0) ? 16'd1 : phase_ticks_reg;
    assign step_end   = (({1'b0, tick_reg} + 17'd1) >= {1'b0, limit});
    assign rx_shifted = {rx_reg[6:0], req.sda_in};

    // next state for one tick
    always_comb
    begin
        seg_next     = seg_reg;
        sub_next     = sub_reg;
        bit_cnt_next = bit_cnt_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        tick_next    = tick_reg;
        dev_next     = dev_reg;
        regaddr_next = regaddr_reg;
        wdata_next   = wdata_reg;
        cmd_next     = cmd_reg;
        rdata_next   = rdata_reg;
        enter        = 1'b0;
        enter_seg    = SEG_IDLE;
        done         = 1'b0;

        unique case (seg_reg)
            SEG_START, SEG_RESTART, SEG_STOP:
            begin
                if (!step_end)
                begin
                    tick_next = tick_reg + 16'd1;
                end
                else if (sub_reg < COND_LAST_SUB)
                begin
                    tick_next = 16'd0;
                    sub_next  = sub_reg + 2'd1;
                end
                else
                begin
                    enter = 1'b1;
                    if (seg_reg == SEG_START)
                    begin
                        enter_seg = SEG_DEVW;
                    end
                    else if (seg_reg == SEG_RESTART)
                    begin
                        enter_seg = SEG_DEVR;
                    end
                    else
                    begin
                        enter_seg = SEG_IDLE;
                        done      = 1'b1;
                    end
                end
            end
            SEG_DEVW, SEG_REG, SEG_DATA, SEG_DEVR, SEG_RECV:
            begin
                if (!step_end)
                begin
                    tick_next = tick_reg + 16'd1;
                end
                else if (sub_reg == 2'd0)
                begin
                    tick_next = 16'd0;
                    sub_next  = 2'd1;
                end
                else if (bit_cnt_reg < BYTE_BITS)
                begin
                    // end of a bit's high phase
                    tick_next = 16'd0;
                    if (seg_reg == SEG_RECV)
                    begin
                        rx_next = rx_shifted;
                        if (bit_cnt_reg == LAST_BIT)
                        begin
                            rdata_next = rx_shifted;
                        end
                    end
                    else
                    begin
                        tx_next = {tx_reg[6:0], 1'b0};
                    end
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    sub_next     = 2'd0;
                end
                else
                begin
                    // ack or nack clock done, move on
                    enter = 1'b1;
                    unique case (seg_reg)
                        SEG_DEVW: enter_seg = SEG_REG;
                        SEG_REG:  enter_seg = (cmd_reg == CMD_READ) ? SEG_RESTART : SEG_DATA;
                        SEG_DATA: enter_seg = SEG_STOP;
                        SEG_DEVR: enter_seg = SEG_RECV;
                        default:  enter_seg = SEG_STOP;
                    endcase
                end
            end
            default:
            begin
                // idle: latch a new request
                seg_next = SEG_IDLE;
                if (req.start_request)
                begin
                    dev_next     = req.device_address;
                    regaddr_next = req.register_address;
                    wdata_next   = req.write_data;
                    cmd_next     = req.command;
                    enter        = 1'b1;
                    enter_seg    = SEG_START;
                end
            end
        endcase

        // segment entry: clear counters, load the byte to send
        if (enter)
        begin
            seg_next     = enter_seg;
            sub_next     = 2'd0;
            bit_cnt_next = 4'd0;
            tick_next    = 16'd0;
            unique case (enter_seg)
                SEG_DEVW: tx_next = {dev_next, RW_WRITE};
                SEG_REG:  tx_next = regaddr_next;
                SEG_DATA: tx_next = wdata_next;
                SEG_DEVR: tx_next = {dev_next, RW_READ};
                SEG_RECV: rx_next = 8'd0;
                default:  ;
            endcase
        end
    end

    // bus levels after this tick's update
    always_comb
    begin
        rsp.busy_res  = (seg_next != SEG_IDLE);
        rsp.done_res  = done;
        rsp.read_data = rdata_next;
        unique case (seg_next)
            SEG_START, SEG_RESTART:
            begin
                rsp.scl_out = (sub_next != 2'd0);
                rsp.sda_out = (sub_next != 2'd2);
            end
            SEG_STOP:
            begin
                rsp.scl_out = (sub_next != 2'd0);
                rsp.sda_out = (sub_next == 2'd2);
            end
            SEG_DEVW, SEG_REG, SEG_DATA, SEG_DEVR:
            begin
                rsp.scl_out = sub_next[0];
                rsp.sda_out = (bit_cnt_next < BYTE_BITS) ? tx_next[7] : 1'b1;
            end
            SEG_RECV:
            begin
                rsp.scl_out = sub_next[0];
                rsp.sda_out = 1'b1;
            end
            default:
            begin
                rsp.scl_out = 1'b0;
                rsp.sda_out = 1'b1;
            end
        endcase
    end

    // state registers, updated once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg     <= SEG_IDLE;
            sub_reg     <= 2'd0;
            bit_cnt_reg <= 4'd0;
            tx_reg      <= 8'd0;
            rx_reg      <= 8'd0;
            tick_reg    <= 16'd0;
            dev_reg     <= 7'd0;
            regaddr_reg <= 8'd0;
            wdata_reg   <= 8'd0;
            cmd_reg     <= CMD_WRITE;
            rdata_reg   <= 8'd0;
        end
        else if (step)
        begin
            seg_reg     <= seg_next;
            sub_reg     <= sub_next;
            bit_cnt_reg <= bit_cnt_next;
            tx_reg      <= tx_next;
            rx_reg      <= rx_next;
            tick_reg    <= tick_next;
            dev_reg     <= dev_next;
            regaddr_reg <= regaddr_next;
            wdata_reg   <= wdata_next;
            cmd_reg     <= cmd_next;
            rdata_reg   <= rdata_next;
        end
    end

endmodule

// ----- rtl/i2cram_checker.sv -----
// port-level checks for the i2c register access master, bound to the top level
// depends on i2cram_pkg
module i2cram_checker
    import i2cram_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input i2cram_out_t rsp_data
);

    // a stalled response beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response beat changed");

    // request side only stalls after a response stall
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
    else $error("request stall without response backpressure");

    // done ends the transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
    else $error("done while still busy");

    // idle bus levels
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.busy_res |-> !rsp_data.scl_out && rsp_data.sda_out)
    else $error("bus not at idle levels while not busy");

endmodule

bind i2c_register_access_master i2cram_checker u_i2cram_checker (.*);
